// File: rtl/core/rrwl_pkg.sv
// Package for the recursive reader-writer lock unit.
// Holds payload widths, action and status codes and the request/result structs.
// No dependencies.
`timescale 1ns / 1ps

package rrwl_pkg;

  localparam int ACTION_W = 3;
  localparam int REQ_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_EXCL_LOCK     = 3'd0,
    ACT_EXCL_TRY      = 3'd1,
    ACT_UNLOCK        = 3'd2,
    ACT_SHARED_LOCK   = 3'd3,
    ACT_SHARED_UNLOCK = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 2'd0,
    ST_BUSY    = 2'd1,
    ST_PENDING = 2'd2,
    ST_ERROR   = 2'd3
  } status_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [REQ_W-1:0]    requester;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                holds_exclusive;
    logic [COUNT_W-1:0]  readers_now;
    logic [COUNT_W-1:0]  depth_now;
  } rsp_t;

endpackage

// File: rtl/core/rrwl_req_if.sv
// Request channel interface for the lock unit: valid, ready and request payload.
// Depends on rrwl_pkg for field widths.
`timescale 1ns / 1ps

interface rrwl_req_if;
  logic                         valid;
  logic                         ready;
  logic [rrwl_pkg::ACTION_W-1:0] action;
  logic [rrwl_pkg::REQ_W-1:0]    requester;

  modport source (output valid, action, requester, input ready);
  modport sink   (input valid, action, requester, output ready);
endinterface

// File: rtl/core/rrwl_rsp_if.sv
// Result channel interface for the lock unit: valid, ready and result payload.
// Depends on rrwl_pkg for field widths.
`timescale 1ns / 1ps

interface rrwl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rrwl_pkg::STATUS_W-1:0] status;
  logic                          holds_exclusive;
  logic [rrwl_pkg::COUNT_W-1:0]  readers_now;
  logic [rrwl_pkg::COUNT_W-1:0]  depth_now;

  modport source (output valid, status, holds_exclusive, readers_now, depth_now,
                  input ready);
  modport sink   (input valid, status, holds_exclusive, readers_now, depth_now,
                  output ready);
endinterface

// File: rtl/core/recursive_reader_writer_lock_unit.sv
// Recursive reader-writer lock unit: one request in, one result out, per
// transfer. A request is registered, decided combinationally against the lock
// state and its result registered, so the unit takes one request every cycle
// while the output does not stall. A result is offered once it has passed the
// input register and the result register; a result held by the output stalls
// the input. The rate is set by the holder, depth and shared-count registers,
// which update at the same edge that registers the result.
// Depends on rrwl_pkg, rrwl_req_if, rrwl_rsp_if and the rrwl_* stage modules.
`timescale 1ns / 1ps

module recursive_reader_writer_lock_unit #(
  parameter int ID_BITS     = 4,
  parameter int MAX_DEPTH   = 255,
  parameter int MAX_READERS = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  rrwl_req_if.sink   in_req,
  rrwl_rsp_if.source out_rsp
);

  logic           s1_valid;
  logic           can_load;
  logic           adv;
  rrwl_pkg::req_t s1_req;
  rrwl_pkg::rsp_t core_rsp;

  assign adv = s1_valid && can_load;

  rrwl_in_stage u_in (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .adv    (adv),
    .valid  (s1_valid),
    .req    (s1_req)
  );

  rrwl_lock_core #(
    .ID_BITS     (ID_BITS),
    .MAX_DEPTH   (MAX_DEPTH),
    .MAX_READERS (MAX_READERS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (s1_req),
    .rsp   (core_rsp)
  );

  rrwl_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_valid),
    .rsp      (core_rsp),
    .can_load (can_load),
    .out_rsp  (out_rsp)
  );

endmodule

// File: rtl/core/rrwl_in_stage.sv
// Input register of the lock unit: captures one request per transfer.
// Depends on rrwl_pkg and rrwl_req_if.
`timescale 1ns / 1ps

module rrwl_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  rrwl_req_if.sink       in_req,
  input  logic           adv,
  output logic           valid,
  output rrwl_pkg::req_t req
);

  logic           valid_r, valid_nxt;
  rrwl_pkg::req_t req_r;

  assign in_req.ready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (in_req.ready) begin
      valid_nxt = in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_r.action    <= in_req.action;
      req_r.requester <= in_req.requester;
    end
  end

  assign valid = valid_r;
  assign req   = req_r;

endmodule

// File: rtl/core/rrwl_lock_core.sv
// Lock state registers and the combinational decision logic for one request.
// Depends on rrwl_pkg.
`timescale 1ns / 1ps

module rrwl_lock_core #(
  parameter int ID_BITS     = 4,
  parameter int MAX_DEPTH   = 255,
  parameter int MAX_READERS = 255
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  rrwl_pkg::req_t req,
  output rrwl_pkg::rsp_t rsp
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int RDR_W   = $clog2(MAX_READERS + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [RDR_W-1:0]   RDR_MAX   = RDR_W'(MAX_READERS);

  logic               gate_r, gate_nxt;
  logic [ID_BITS-1:0] holder_r, holder_nxt;
  logic               granted_r, granted_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [RDR_W-1:0]   readers_r, readers_nxt;

  logic               [ID_BITS-1:0] id;
  logic               mine, owns, resv_mine;
  rrwl_pkg::status_t  status;

  assign id        = ID_BITS'(req.requester);
  assign mine      = gate_r && (holder_r == id);
  assign owns      = mine && granted_r;
  assign resv_mine = mine && !granted_r;

  always_comb begin
    gate_nxt    = gate_r;
    holder_nxt  = holder_r;
    granted_nxt = granted_r;
    depth_nxt   = depth_r;
    readers_nxt = readers_r;
    status      = rrwl_pkg::ST_ERROR;
    unique case (rrwl_pkg::action_t'(req.action))
      rrwl_pkg::ACT_EXCL_LOCK, rrwl_pkg::ACT_EXCL_TRY: begin
        priority if (owns) begin
          if (depth_r >= DEPTH_MAX) begin
            status = rrwl_pkg::ST_ERROR;
          end else begin
            depth_nxt = depth_r + DEPTH_W'(1);
            status    = rrwl_pkg::ST_GRANTED;
          end
        end else if (resv_mine) begin
          if (readers_r == '0) begin
            granted_nxt = 1'b1;
            depth_nxt   = DEPTH_W'(1);
            status      = rrwl_pkg::ST_GRANTED;
          end else if (req.action == rrwl_pkg::ACT_EXCL_LOCK) begin
            status = rrwl_pkg::ST_PENDING;
          end else begin
            status = rrwl_pkg::ST_BUSY;
          end
        end else if (gate_r) begin
          status = rrwl_pkg::ST_BUSY;
        end else if (readers_r == '0) begin
          gate_nxt    = 1'b1;
          holder_nxt  = id;
          granted_nxt = 1'b1;
          depth_nxt   = DEPTH_W'(1);
          status      = rrwl_pkg::ST_GRANTED;
        end else if (req.action == rrwl_pkg::ACT_EXCL_LOCK) begin
          gate_nxt    = 1'b1;
          holder_nxt  = id;
          granted_nxt = 1'b0;
          depth_nxt   = '0;
          status      = rrwl_pkg::ST_PENDING;
        end else begin
          status = rrwl_pkg::ST_BUSY;
        end
      end
      rrwl_pkg::ACT_UNLOCK: begin
        if (owns && (depth_r > DEPTH_W'(1))) begin
          depth_nxt = depth_r - DEPTH_W'(1);
          status    = rrwl_pkg::ST_GRANTED;
        end else if (mine) begin
          gate_nxt    = 1'b0;
          holder_nxt  = '0;
          granted_nxt = 1'b0;
          depth_nxt   = '0;
          status      = rrwl_pkg::ST_GRANTED;
        end else begin
          status = rrwl_pkg::ST_ERROR;
        end
      end
      rrwl_pkg::ACT_SHARED_LOCK: begin
        priority if (owns) begin
          status = rrwl_pkg::ST_ERROR;
        end else if (gate_r) begin
          status = rrwl_pkg::ST_BUSY;
        end else if (readers_r >= RDR_MAX) begin
          status = rrwl_pkg::ST_ERROR;
        end else begin
          readers_nxt = readers_r + RDR_W'(1);
          status      = rrwl_pkg::ST_GRANTED;
        end
      end
      rrwl_pkg::ACT_SHARED_UNLOCK: begin
        if (readers_r == '0) begin
          status = rrwl_pkg::ST_ERROR;
        end else begin
          readers_nxt = readers_r - RDR_W'(1);
          status      = rrwl_pkg::ST_GRANTED;
        end
      end
      default: begin
        status = rrwl_pkg::ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r    <= 1'b0;
      holder_r  <= '0;
      granted_r <= 1'b0;
      depth_r   <= '0;
      readers_r <= '0;
    end else if (adv) begin
      gate_r    <= gate_nxt;
      holder_r  <= holder_nxt;
      granted_r <= granted_nxt;
      depth_r   <= depth_nxt;
      readers_r <= readers_nxt;
    end
  end

  assign rsp.status          = status;
  assign rsp.holds_exclusive = gate_nxt && granted_nxt && (holder_nxt == id);
  assign rsp.readers_now     = rrwl_pkg::COUNT_W'(readers_nxt);
  assign rsp.depth_now       = rrwl_pkg::COUNT_W'(depth_nxt);

endmodule

// File: rtl/core/rrwl_out_stage.sv
// Result register of the lock unit: holds one result until its transfer.
// Depends on rrwl_pkg and rrwl_rsp_if.
`timescale 1ns / 1ps

module rrwl_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  rrwl_pkg::rsp_t rsp,
  output logic           can_load,
  rrwl_rsp_if.source     out_rsp
);

  logic           valid_r, valid_nxt;
  rrwl_pkg::rsp_t rsp_r;

  assign can_load = !valid_r || out_rsp.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      rsp_r <= rsp;
    end
  end

  assign out_rsp.valid           = valid_r;
  assign out_rsp.status          = rsp_r.status;
  assign out_rsp.holds_exclusive = rsp_r.holds_exclusive;
  assign out_rsp.readers_now     = rsp_r.readers_now;
  assign out_rsp.depth_now       = rsp_r.depth_now;

endmodule

// File: tb/sv/tb_recursive_reader_writer_lock_unit.sv
// Testbench for recursive_reader_writer_lock_unit: directed table, depth and
// shared-count climbs, then state-aware random requests, all checked in order.
// Depends on rrwl_pkg, rrwl_req_if, rrwl_rsp_if and the lock unit RTL.
`timescale 1ns / 1ps

module tb_recursive_reader_writer_lock_unit;

  localparam int ACTION_W    = rrwl_pkg::ACTION_W;
  localparam int REQ_W       = rrwl_pkg::REQ_W;
  localparam int COUNT_W     = rrwl_pkg::COUNT_W;
  localparam int ID_BITS     = 4;
  localparam int MAX_DEPTH   = 255;
  localparam int MAX_READERS = 255;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MIXED_ITEMS = 40;

  localparam logic [ACTION_W-1:0] ACT_RSVD_5 = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_7 = 3'd7;

  localparam bit CHK = 1'b1;
  localparam bit PRD = 1'b0;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [REQ_W-1:0]    rid;
    bit                  typed;
    rrwl_pkg::status_t   st;
    logic                own;
    logic [COUNT_W-1:0]  rd;
    logic [COUNT_W-1:0]  dp;
  } lock_row_t;

  localparam int N_ROWS = 27;
  localparam lock_row_t LOCK_ROWS [N_ROWS] = '{
    '{rrwl_pkg::ACT_SHARED_UNLOCK, 4'd0,  CHK, rrwl_pkg::ST_ERROR,   1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_UNLOCK,        4'd5,  CHK, rrwl_pkg::ST_ERROR,   1'b0, 8'd0, 8'd0},
    '{ACT_RSVD_5,                  4'd15, CHK, rrwl_pkg::ST_ERROR,   1'b0, 8'd0, 8'd0},
    '{ACT_RSVD_6,                  4'd8,  CHK, rrwl_pkg::ST_ERROR,   1'b0, 8'd0, 8'd0},
    '{ACT_RSVD_7,                  4'd7,  CHK, rrwl_pkg::ST_ERROR,   1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_EXCL_LOCK,     4'd3,  CHK, rrwl_pkg::ST_GRANTED, 1'b1, 8'd0, 8'd1},
    '{rrwl_pkg::ACT_EXCL_TRY,      4'd3,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_EXCL_LOCK,     4'd4,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_SHARED_LOCK,   4'd3,  CHK, rrwl_pkg::ST_ERROR,   1'b1, 8'd0, 8'd2},
    '{rrwl_pkg::ACT_SHARED_LOCK,   4'd7,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_UNLOCK,        4'd4,  CHK, rrwl_pkg::ST_ERROR,   1'b0, 8'd0, 8'd2},
    '{rrwl_pkg::ACT_UNLOCK,        4'd3,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_UNLOCK,        4'd3,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_SHARED_LOCK,   4'd1,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_EXCL_TRY,      4'd2,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_EXCL_LOCK,     4'd2,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_EXCL_LOCK,     4'd2,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_EXCL_TRY,      4'd2,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_EXCL_LOCK,     4'd9,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_SHARED_LOCK,   4'd9,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_SHARED_UNLOCK, 4'd0,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_EXCL_TRY,      4'd2,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_UNLOCK,        4'd2,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_SHARED_LOCK,   4'd0,  PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_EXCL_LOCK,     4'd15, PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_UNLOCK,        4'd15, PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0},
    '{rrwl_pkg::ACT_SHARED_UNLOCK, 4'd15, PRD, rrwl_pkg::ST_GRANTED, 1'b0, 8'd0, 8'd0}
  };

  logic clk;
  logic rst_n;

  rrwl_req_if req_ch ();
  rrwl_rsp_if rsp_ch ();

  recursive_reader_writer_lock_unit #(
    .ID_BITS     (ID_BITS),
    .MAX_DEPTH   (MAX_DEPTH),
    .MAX_READERS (MAX_READERS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // shadow lock state
  bit               gate_held;
  logic [REQ_W-1:0] gate_owner;
  bit               gate_granted;
  int               excl_depth;
  int               shared_count;

  rrwl_pkg::rsp_t due_results [$];
  int             n_sent;
  int             n_checked;
  int             n_fail;
  int             n_cycles;
  int             burst_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               due_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic rrwl_pkg::rsp_t arbitrate_request(input logic [ACTION_W-1:0] act,
                                                       input logic [REQ_W-1:0]    rid);
    rrwl_pkg::rsp_t    res;
    bit                mine;
    bit                owns;
    bit                resv;
    rrwl_pkg::status_t st;
    mine = gate_held && (gate_owner == rid);
    owns = mine && gate_granted;
    resv = mine && !gate_granted;
    st   = rrwl_pkg::ST_ERROR;
    case (act)
      rrwl_pkg::ACT_EXCL_LOCK, rrwl_pkg::ACT_EXCL_TRY: begin
        if (owns) begin
          if (excl_depth < MAX_DEPTH) begin
            excl_depth++;
            st = rrwl_pkg::ST_GRANTED;
          end
        end else if ((resv || !gate_held) && shared_count == 0) begin
          gate_held    = 1'b1;
          gate_owner   = rid;
          gate_granted = 1'b1;
          excl_depth   = 1;
          st           = rrwl_pkg::ST_GRANTED;
        end else if (resv) begin
          st = (act == rrwl_pkg::ACT_EXCL_LOCK) ? rrwl_pkg::ST_PENDING : rrwl_pkg::ST_BUSY;
        end else if (gate_held) begin
          st = rrwl_pkg::ST_BUSY;
        end else if (act == rrwl_pkg::ACT_EXCL_LOCK) begin
          // reserve and wait for the shared holders to drain
          gate_held    = 1'b1;
          gate_owner   = rid;
          gate_granted = 1'b0;
          excl_depth   = 0;
          st           = rrwl_pkg::ST_PENDING;
        end else begin
          st = rrwl_pkg::ST_BUSY;
        end
      end
      rrwl_pkg::ACT_UNLOCK: begin
        if (owns && excl_depth > 1) begin
          excl_depth--;
          st = rrwl_pkg::ST_GRANTED;
        end else if (mine) begin
          gate_held    = 1'b0;
          gate_owner   = '0;
          gate_granted = 1'b0;
          excl_depth   = 0;
          st           = rrwl_pkg::ST_GRANTED;
        end
      end
      rrwl_pkg::ACT_SHARED_LOCK: begin
        if (owns) begin
          st = rrwl_pkg::ST_ERROR;
        end else if (gate_held) begin
          st = rrwl_pkg::ST_BUSY;
        end else if (shared_count < MAX_READERS) begin
          shared_count++;
          st = rrwl_pkg::ST_GRANTED;
        end
      end
      rrwl_pkg::ACT_SHARED_UNLOCK: begin
        if (shared_count > 0) begin
          shared_count--;
          st = rrwl_pkg::ST_GRANTED;
        end
      end
      default: st = rrwl_pkg::ST_ERROR;
    endcase
    res.status          = st;
    res.holds_exclusive = gate_held && gate_granted && (gate_owner == rid);
    res.readers_now     = COUNT_W'(shared_count);
    res.depth_now       = COUNT_W'(excl_depth);
    return res;
  endfunction

  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [REQ_W-1:0]    rid,
                              input bit                  typed,
                              input rrwl_pkg::rsp_t      typed_rsp);
    rrwl_pkg::rsp_t guess;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.requester <= rid;
    do @(posedge clk); while (!req_ch.ready);
    guess = arbitrate_request(act, rid);
    due_results.push_back(typed ? typed_rsp : guess);
    n_sent++;
  endtask

  task automatic send_plain(input logic [ACTION_W-1:0] act, input logic [REQ_W-1:0] rid);
    send_request(act, rid, PRD, '0);
  endtask

  task automatic wait_results_drained();
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // result side: check every transfer, stall on a pattern of its own
  initial begin
    rrwl_pkg::rsp_t want;
    int             phase_left;
    int             phase_kind;
    int             holdoff_left;
    bit             holdoff_done;
    bit             next_ready;
    phase_left   = 0;
    phase_kind   = 0;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          n_fail++;
        end else begin
          want = due_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            n_fail++;
          end
          if (rsp_ch.holds_exclusive !== want.holds_exclusive) begin
            $error("holds_exclusive: expected %0d, got %0d", want.holds_exclusive,
                   rsp_ch.holds_exclusive);
            n_fail++;
          end
          if (rsp_ch.readers_now !== want.readers_now) begin
            $error("readers_now: expected %0d, got %0d", want.readers_now,
                   rsp_ch.readers_now);
            n_fail++;
          end
          if (rsp_ch.depth_now !== want.depth_now) begin
            $error("depth_now: expected %0d, got %0d", want.depth_now, rsp_ch.depth_now);
            n_fail++;
          end
          n_checked++;
        end
      end
      if (!holdoff_done && n_checked >= 100) begin
        holdoff_done = 1'b1;
        holdoff_left = 80;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(5, 40);
        phase_kind = $urandom_range(0, 2);
      end
      phase_left--;
      if (holdoff_left > 0) begin
        holdoff_left--;
        next_ready = 1'b0;
      end else begin
        case (phase_kind)
          0:       next_ready = 1'b1;
          1:       next_ready = ($urandom_range(0, 3) != 0);
          default: next_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      rsp_ch.ready <= next_ready;
    end
  end

  initial begin
    rrwl_pkg::rsp_t      row_rsp;
    logic [REQ_W-1:0]    who;
    logic [REQ_W-1:0]    other;
    logic [ACTION_W-1:0] act;
    int                  r;
    bit                  hit;
    gate_held        = 1'b0;
    gate_owner       = '0;
    gate_granted     = 1'b0;
    excl_depth       = 0;
    shared_count     = 0;
    n_sent           = 0;
    n_checked        = 0;
    n_fail           = 0;
    n_cycles         = 0;
    burst_left       = 0;
    rst_n            <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.action    <= '0;
    req_ch.requester <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      row_rsp.status          = LOCK_ROWS[i].st;
      row_rsp.holds_exclusive = LOCK_ROWS[i].own;
      row_rsp.readers_now     = LOCK_ROWS[i].rd;
      row_rsp.depth_now       = LOCK_ROWS[i].dp;
      send_request(LOCK_ROWS[i].act, LOCK_ROWS[i].rid, LOCK_ROWS[i].typed, row_rsp);
    end

    // recursion up to the depth limit and back, with other requesters cutting in
    who = REQ_W'($urandom_range(0, 15));
    send_plain(rrwl_pkg::ACT_EXCL_LOCK, who);
    hit = 1'b0;
    while (!hit) begin
      if ($urandom_range(0, 31) == 0) begin
        other = who ^ REQ_W'($urandom_range(1, 15));
        send_plain(ACTION_W'($urandom_range(0, 4)), other);
      end else begin
        if (excl_depth == MAX_DEPTH) hit = 1'b1;
        act = $urandom_range(0, 1) ? rrwl_pkg::ACT_EXCL_LOCK : rrwl_pkg::ACT_EXCL_TRY;
        send_plain(act, who);
      end
    end
    while (gate_held) begin
      if ($urandom_range(0, 31) == 0) begin
        other = who ^ REQ_W'($urandom_range(1, 15));
        send_plain(ACTION_W'($urandom_range(0, 4)), other);
      end else begin
        send_plain(rrwl_pkg::ACT_UNLOCK, who);
      end
    end

    req_ch.valid <= 1'b0;
    burst_left = 1;
    wait_results_drained();

    // shared count up to its limit, with a little noise on a free gate
    hit = 1'b0;
    while (!hit) begin
      r   = $urandom_range(0, 31);
      who = REQ_W'($urandom_range(0, 15));
      if (r == 0 && shared_count > 0) begin
        send_plain(rrwl_pkg::ACT_EXCL_TRY, who);
      end else if (r == 1) begin
        send_plain(rrwl_pkg::ACT_UNLOCK, who);
      end else if (r == 2) begin
        send_plain(rrwl_pkg::ACT_SHARED_UNLOCK, who);
      end else begin
        if (shared_count == MAX_READERS) hit = 1'b1;
        send_plain(rrwl_pkg::ACT_SHARED_LOCK, who);
      end
    end

    // mixed traffic on a crowded lock: reservations, cancels and some noise
    for (int i = 0; i < MIXED_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_plain(ACTION_W'($urandom_range(0, 7)), REQ_W'($urandom_range(0, 15)));
      end else if (gate_held && r < 55) begin
        if (r < 30) begin
          send_plain(rrwl_pkg::ACT_UNLOCK, gate_owner);
        end else begin
          act = $urandom_range(0, 1) ? rrwl_pkg::ACT_EXCL_LOCK : rrwl_pkg::ACT_EXCL_TRY;
          send_plain(act, gate_owner);
        end
      end else if (gate_held) begin
        send_plain(ACTION_W'($urandom_range(0, 4)), REQ_W'($urandom_range(0, 15)));
      end else begin
        who = REQ_W'($urandom_range(0, 3));
        if (r < 45) send_plain(rrwl_pkg::ACT_SHARED_LOCK, who);
        else if (r < 72) send_plain(rrwl_pkg::ACT_SHARED_UNLOCK, who);
        else if (r < 88) send_plain(rrwl_pkg::ACT_EXCL_LOCK, who);
        else send_plain(rrwl_pkg::ACT_EXCL_TRY, who);
      end
    end

    req_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (10) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d mismatches", n_sent, n_checked,
             n_fail);
    $display("covered: misuse and reservation cases, recursion and shared count at their");
    $display("limits, and random requests against a crowded lock under output stalls");
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rrwl_pkg.sv
rtl/core/rrwl_req_if.sv
rtl/core/rrwl_rsp_if.sv
rtl/core/rrwl_in_stage.sv
rtl/core/rrwl_lock_core.sv
rtl/core/rrwl_out_stage.sv
rtl/core/recursive_reader_writer_lock_unit.sv
tb/sv/tb_recursive_reader_writer_lock_unit.sv
